FILE: src/utf8d_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 sequence decoder.
// No dependencies; the RTL modules and the bench import this package.
`default_nettype none
package utf8d_pkg;

   localparam int unsigned CP_WIDTH  = 31;
   localparam int unsigned LEN_WIDTH = 3;
   localparam int unsigned CNT_WIDTH = 3;

   // Trailing-byte count reported for a lead byte that cannot start a sequence.
   localparam logic [CNT_WIDTH-1:0] LEAD_BAD = 3'd6;
   localparam logic [CNT_WIDTH-1:0] MAX_TRAIL = 3'd5;

   localparam logic [CP_WIDTH-1:0] SURR_LO   = 31'h0000_D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI   = 31'h0000_DFFF;
   localparam logic [CP_WIDTH-1:0] NONCHAR_E = 31'h0000_FFFE;
   localparam logic [CP_WIDTH-1:0] NONCHAR_F = 31'h0000_FFFF;

   localparam logic [7:0] TRAIL_TAG_MASK = 8'hC0;
   localparam logic [7:0] TRAIL_TAG      = 8'h80;
   localparam logic [7:0] TRAIL_BITS     = 8'h3F;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_TRUNC   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0]  code_point;
      logic [LEN_WIDTH-1:0] seq_length;
      status_type           status;
   } rsp_item_type;

   // Number of trailing bytes announced by a lead byte; LEAD_BAD for a bad lead.
   function automatic logic [CNT_WIDTH-1:0] lead_count(input logic [7:0] b);
      logic [CNT_WIDTH-1:0] n;
      if (b < 8'h80)      n = 3'd0;
      else if (b < 8'hC2) n = LEAD_BAD;
      else if (b < 8'hE0) n = 3'd1;
      else if (b < 8'hF0) n = 3'd2;
      else if (b < 8'hF8) n = 3'd3;
      else if (b < 8'hFC) n = 3'd4;
      else if (b < 8'hFE) n = 3'd5;
      else                n = LEAD_BAD;
      return n;
   endfunction

   // Payload bits of a lead byte that opens a sequence with n trailers.
   function automatic logic [7:0] lead_mask(input logic [CNT_WIDTH-1:0] n);
      logic [7:0] m;
      case (n)
         3'd1:    m = 8'h1F;
         3'd2:    m = 8'h0F;
         3'd3:    m = 8'h07;
         3'd4:    m = 8'h03;
         3'd5:    m = 8'h01;
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

   // Smallest value that a sequence with n trailers may legally carry.
   function automatic logic [CP_WIDTH-1:0] least_value(input logic [CNT_WIDTH-1:0] n);
      logic [CP_WIDTH-1:0] v;
      case (n)
         3'd1:    v = 31'h0000_0080;
         3'd2:    v = 31'h0000_0800;
         3'd3:    v = 31'h0001_0000;
         3'd4:    v = 31'h0020_0000;
         3'd5:    v = 31'h0400_0000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage : utf8d_pkg
`default_nettype wire

FILE: src/utf8d_ifs.sv
// Valid/ready channel interfaces for the byte input and the decoded result.
// Depends on: nothing (plain logic payload fields).
`default_nettype none
interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface : utf8d_req_if

interface utf8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] code_point;
   logic [2:0]  seq_length;
   logic [1:0]  status;

   modport source (output valid, output code_point, output seq_length, output status,
                   input ready);
   modport sink   (input valid, input code_point, input seq_length, input status,
                   output ready);
endinterface : utf8d_rsp_if
`default_nettype wire

FILE: src/utf8d_req_reg.sv
// Input register stage: captures one byte transfer per cycle while its slot is free.
// Depends on: utf8d_pkg, utf8d_req_if.
`default_nettype none
module utf8d_req_reg
   import utf8d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   utf8d_req_if.sink    req_ch,
   input  wire logic    consume,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   // Slot is free when empty or when the held byte retires this cycle.
   assign req_ch.ready = !valid_ff || consume;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.ready) begin
         valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte     <= req_ch.data_byte;
         item_ff.end_of_buffer <= req_ch.end_of_buffer;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule : utf8d_req_reg
`default_nettype wire

FILE: src/utf8d_core.sv
// Decode step: sequence state registers plus the per-byte decode logic.
// Depends on: utf8d_pkg.
`default_nettype none
module utf8d_core
   import utf8d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   input  wire req_item_type  item,
   input  wire logic          rsp_free,
   output logic               consume,
   output logic               res_valid,
   output rsp_item_type       res
);

   logic [CNT_WIDTH-1:0] left_ff, left_in;
   logic [CNT_WIDTH-1:0] total_ff, total_in;
   logic [CP_WIDTH-1:0]  value_ff, value_in;

   logic                 emit;
   rsp_item_type         res_c;

   always_comb begin
      logic                 idle;
      logic [CNT_WIDTH-1:0] n;
      logic [CNT_WIDTH-1:0] left_dec;
      logic [CP_WIDTH-1:0]  v;
      logic [7:0]           b;
      logic                 last;

      b        = item.data_byte;
      last     = item.end_of_buffer;
      idle     = (left_ff == '0) || (left_ff > MAX_TRAIL) || (total_ff > MAX_TRAIL);
      n        = lead_count(b);
      left_dec = left_ff - 3'd1;
      v        = {value_ff[CP_WIDTH-7:0], b[5:0]};

      left_in  = '0;
      total_in = '0;
      value_in = '0;
      emit     = 1'b0;
      res_c.code_point = '0;
      res_c.seq_length = '0;
      res_c.status     = ST_OK;

      if (idle) begin
         if (n == LEAD_BAD) begin
            emit         = 1'b1;
            res_c.status = ST_INVALID;
         end else if (n == '0) begin
            emit             = 1'b1;
            res_c.code_point = {{(CP_WIDTH-8){1'b0}}, b};
            res_c.seq_length = 3'd1;
         end else if (last) begin
            emit         = 1'b1;
            res_c.status = ST_TRUNC;
         end else begin
            left_in  = n;
            total_in = n;
            value_in = {{(CP_WIDTH-8){1'b0}}, b & lead_mask(n)};
         end
      end else if ((b & TRAIL_TAG_MASK) != TRAIL_TAG) begin
         // Bad trailer: report now and drop the open sequence.
         emit         = 1'b1;
         res_c.status = ST_INVALID;
      end else if (left_dec == '0) begin
         emit = 1'b1;
         if ((v < least_value(total_ff)) || (v == NONCHAR_F) || (v == NONCHAR_E) ||
             ((v >= SURR_LO) && (v <= SURR_HI))) begin
            res_c.status = ST_INVALID;
         end else begin
            res_c.code_point = v;
            res_c.seq_length = total_ff + 3'd1;
         end
      end else if (last) begin
         emit         = 1'b1;
         res_c.status = ST_TRUNC;
      end else begin
         left_in  = left_dec;
         total_in = total_ff;
         value_in = v;
      end
   end

   // A byte retires unless its result has nowhere to go.
   assign consume   = item_valid && (!emit || rsp_free);
   assign res_valid = item_valid && emit && rsp_free;
   assign res       = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         total_ff <= '0;
         value_ff <= '0;
      end else if (consume) begin
         left_ff  <= left_in;
         total_ff <= total_in;
         value_ff <= value_in;
      end
   end

`ifndef ASSERT_OFF
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_TRAIL)
      else $error("trailer total out of range");

   a_left_le_total: assert property (@(posedge clock) disable iff (reset)
      left_ff <= total_ff)
      else $error("more trailers left than announced");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status != ST_OK) |-> (res.code_point == '0) && (res.seq_length == '0))
      else $error("error result carries a value");

   a_eob_idle: assert property (@(posedge clock) disable iff (reset)
      consume && item.end_of_buffer |=> (left_ff == '0) && (total_ff == '0))
      else $error("sequence still open after end of buffer");
`endif

endmodule : utf8d_core
`default_nettype wire

FILE: src/utf8d_rsp_reg.sv
// Result register: holds one decoded result until the sink takes it.
// Depends on: utf8d_pkg, utf8d_rsp_if.
`default_nettype none
module utf8d_rsp_reg
   import utf8d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire rsp_item_type  res,
   output logic               rsp_free,
   utf8d_rsp_if.source        rsp_ch
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   assign rsp_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.code_point = data_ff.code_point;
   assign rsp_ch.seq_length = data_ff.seq_length;
   assign rsp_ch.status     = data_ff.status;

endmodule : utf8d_rsp_reg
`default_nettype wire

FILE: src/utf8_sequence_decoder.sv
// Top level of the six-byte validating UTF-8 decoder.
// Depends on: utf8d_pkg, utf8d_ifs, utf8d_req_reg, utf8d_core, utf8d_rsp_reg.
//
// Byte-serial decoder for the original UTF-8 form (one to six bytes, code
// points up to 0x7FFFFFFF). It takes one byte transfer per clock. While a
// finished result waits in the output register it still takes bytes that
// finish nothing, and holds the first byte that needs a result of its own
// until the sink frees the register; a stalled result sink is the only
// throttle. A byte is captured in the input register, decoded against the
// open-sequence state, and any result is loaded into the result register,
// which drives rsp valid until the sink takes it. Each byte yields at
// most one result: a single-byte character, a completed sequence, or an
// error (status 1 for a bad lead, a bad trailer, an overlong form, a
// surrogate or U+FFFE/U+FFFF; status 2 when end_of_buffer closes a byte that
// leaves a sequence incomplete). Lead and continuation bytes of an open
// sequence produce nothing. On error the open sequence and the offending
// byte are dropped and decoding restarts with the next byte as a lead.
// The throughput is set by the single decode step, which has to see the
// state left by the previous byte: one byte per cycle while the result
// sink keeps up.
`default_nettype none
module utf8_sequence_decoder
   import utf8d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   utf8d_req_if.sink   req_ch,
   utf8d_rsp_if.source rsp_ch
);

   logic         item_valid;
   req_item_type item;
   logic         consume;
   logic         res_valid;
   rsp_item_type res;
   logic         rsp_free;

   // Input register; frees its slot as soon as the held byte retires.
   utf8d_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .consume    (consume),
      .item_valid (item_valid),
      .item       (item)
   );

   // Decode step and sequence state.
   utf8d_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .rsp_free   (rsp_free),
      .consume    (consume),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Result register toward the sink.
   utf8d_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .res      (res),
      .rsp_free (rsp_free),
      .rsp_ch   (rsp_ch)
   );

endmodule : utf8_sequence_decoder
`default_nettype wire

FILE: sim/utf8_sequence_decoder_tb.sv
// Self-checking bench for utf8_sequence_decoder: byte stream in, decoded characters out.
// Depends on utf8d_pkg (types, status codes, value limits) and utf8d_ifs (channel interfaces).
// A local decoder mirror predicts every result; a scoreboard process checks each transfer.
`default_nettype none
module utf8_sequence_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import utf8d_pkg::*;

   localparam int MAX_WAIT       = 16;    // longest source gap / sink stall per transfer
   localparam int DRAIN_CYCLES   = 16;    // quiet time after the last expected result
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer before giving up
   localparam int RANDOM_BYTES   = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   utf8d_req_if req_ch();
   utf8d_rsp_if rsp_ch();

   utf8_sequence_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Mirror of the decoder's open-sequence state.
   logic [2:0]  open_trailers;   // continuation bytes still to come
   logic [2:0]  seq_trailers;    // continuation bytes of the open sequence
   logic [30:0] gathered_bits;   // value collected so far

   rsp_item_type expected_chars[$];
   int mismatch_count = 0;
   int idle_cycles    = 0;

   // Per-side idling switches; the random test flips them to get stretches with no gaps.
   bit src_gaps    = 1'b1;
   bit sink_stalls = 1'b1;

   // ------------------------------------------------------------------
   // Decoder mirror
   // ------------------------------------------------------------------

   // Continuation bytes announced by a lead byte. 0xC0/0xC1 can only start
   // an overlong pair, so they are rejected like a stray continuation byte.
   function automatic logic [2:0] trailers_for_lead(input logic [7:0] b);
      casez (b)
         8'b0???????: return 3'd0;
         8'b110?????: return (b[4:1] == 4'b0000) ? LEAD_BAD : 3'd1;
         8'b1110????: return 3'd2;
         8'b11110???: return 3'd3;
         8'b111110??: return 3'd4;
         8'b1111110?: return 3'd5;
         default:     return LEAD_BAD;
      endcase
   endfunction

   // Smallest value that is not overlong for a sequence with n continuation bytes.
   function automatic logic [30:0] floor_for(input int n);
      return (n == 1) ? 31'h80 : (31'd1 << (5 * n + 1));
   endfunction

   function automatic bit forbidden_value(input logic [30:0] v);
      return (v >= SURR_LO && v <= SURR_HI) || v == NONCHAR_E || v == NONCHAR_F;
   endfunction

   task automatic close_sequence();
      open_trailers = '0;
      seq_trailers  = '0;
      gathered_bits = '0;
   endtask

   task automatic push_char(input logic [30:0] cp, input logic [2:0] len,
                            input status_type st);
      rsp_item_type r;
      r.code_point = cp;
      r.seq_length = len;
      r.status     = st;
      expected_chars.push_back(r);
   endtask

   // Advance the mirror by one accepted byte and queue the result it causes, if any.
   task automatic predict_char(input logic [7:0] b, input logic eob);
      logic [2:0]  n;
      logic [30:0] v;
      if (open_trailers == 3'd0) begin
         n = trailers_for_lead(b);
         if (n == LEAD_BAD) begin
            push_char('0, '0, ST_INVALID);
         end else if (n == 3'd0) begin
            push_char({23'd0, b}, 3'd1, ST_OK);
         end else if (eob) begin
            push_char('0, '0, ST_TRUNC);
         end else begin
            open_trailers = n;
            seq_trailers  = n;
            gathered_bits = {23'd0, b & (8'h7F >> (n + 1))};
         end
      end else if ((b & TRAIL_TAG_MASK) != TRAIL_TAG) begin
         // bad continuation byte: sequence and byte are both dropped
         close_sequence();
         push_char('0, '0, ST_INVALID);
      end else begin
         gathered_bits = {gathered_bits[24:0], b[5:0]};
         open_trailers = open_trailers - 3'd1;
         if (open_trailers == 3'd0) begin
            v = gathered_bits;
            n = seq_trailers;
            close_sequence();
            if (v < floor_for(n) || forbidden_value(v))
               push_char('0, '0, ST_INVALID);
            else
               push_char(v, n + 3'd1, ST_OK);
         end else if (eob) begin
            close_sequence();
            push_char('0, '0, ST_TRUNC);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Byte source
   // ------------------------------------------------------------------

   // One byte transfer. valid stays high across back-to-back bytes; it only
   // drops when this byte draws a gap.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      gap = src_gaps ? $urandom_range(MAX_WAIT, 0) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= b;
      req_ch.end_of_buffer <= eob;
      do @(posedge clock); while (!req_ch.ready);
      predict_char(b, eob);
   endtask

   // Bytes of value v encoded in len bytes; byte i sits at [8*i +: 8].
   // Works for overlong encodings as well, as long as v fits len.
   function automatic logic [47:0] encode_char(input logic [30:0] v, input int len);
      logic [47:0] enc;
      int i;
      enc = '0;
      if (len == 1) begin
         enc[7:0] = {1'b0, v[6:0]};
      end else begin
         enc[7:0] = (8'hFF << (8 - len)) | 8'(v >> (6 * (len - 1)));
         for (i = 1; i < len; i++)
            enc[8*i +: 8] = {2'b10, v[6*(len-1-i) +: 6]};
      end
      return enc;
   endfunction

   // Non-overlong value for len bytes, biased toward range edges and refused values.
   function automatic logic [30:0] pick_value(input int len);
      logic [31:0] lo;
      logic [31:0] hi;
      int pick;
      lo   = (len == 1) ? 32'd0 : {1'b0, floor_for(len - 1)};
      hi   = (len == 6) ? 32'h7FFF_FFFF : {1'b0, floor_for(len)} - 32'd1;
      pick = $urandom_range(7, 0);
      if (pick == 0) return lo[30:0];
      if (pick == 1) return hi[30:0];
      if (pick == 2 && len == 3) begin
         case ($urandom_range(6, 0))
            0:       return SURR_LO;
            1:       return SURR_HI;
            2:       return SURR_LO - 31'd1;
            3:       return SURR_HI + 31'd1;
            4:       return NONCHAR_E;
            5:       return NONCHAR_F;
            default: return NONCHAR_E - 31'd1;
         endcase
      end
      return 31'($urandom_range(hi, lo));
   endfunction

   // Send the first count bytes of an encoding; eob goes on the last one sent.
   task automatic send_prefix(input logic [47:0] enc, input int count, input logic eob);
      int i;
      for (i = 0; i < count; i++)
         send_byte(enc[8*i +: 8], (i == count - 1) ? eob : 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Result sink and scoreboard
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ready drops for a random stall ahead of each result transfer
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = sink_stalls ? $urandom_range(MAX_WAIT, 0) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Every result transfer is matched against the oldest prediction, field by field.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected result cp=%h len=%0d status=%0d",
                                      rsp_ch.code_point, rsp_ch.seq_length, rsp_ch.status));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_ch.code_point !== want.code_point)
               report_mismatch($sformatf("code_point %h, expected %h",
                                         rsp_ch.code_point, want.code_point));
            if (rsp_ch.seq_length !== want.seq_length)
               report_mismatch($sformatf("seq_length %0d, expected %0d",
                                         rsp_ch.seq_length, want.seq_length));
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
         end
      end
   end

   // Watchdog: a healthy run never goes this long without a transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // ASCII at both ends of its range; end_of_buffer on a complete byte is harmless.
   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // Stray continuation byte, overlong-only lead, never-valid lead.
   task automatic test_bad_leads();
      send_byte(8'h80, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Six-byte form carrying the largest code point.
   task automatic test_longest_sequence();
      send_prefix(encode_char(31'h7FFF_FFFF, 6), 6, 1'b0);
   endtask

   // Complete sequences whose value is refused: overlong, surrogate, noncharacter.
   task automatic test_rejected_values();
      send_prefix(encode_char(31'h0000_0000, 3), 3, 1'b0);
      send_prefix(encode_char(SURR_LO, 3), 3, 1'b0);
      send_prefix(encode_char(NONCHAR_F, 3), 3, 1'b0);
   endtask

   // Non-continuation byte inside a sequence, with and without end of buffer.
   task automatic test_bad_trailer();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'hC3, 1'b1);
   endtask

   // Buffer ends on a lead byte, then in the middle of a four-byte sequence.
   task automatic test_early_end();
      send_byte(8'hC3, 1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b1);
   endtask

   // Half well-formed characters, plus overlong, cut-short, broken and noise bytes.
   task automatic test_random_streams();
      int sent;
      int kind;
      int len;
      int cut;
      logic [47:0] enc;
      logic [7:0]  b;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         // occasionally change the idling mix so some stretches run gap-free
         if ($urandom_range(15, 0) == 0) begin
            src_gaps    = 1'($urandom_range(1, 0));
            sink_stalls = 1'($urandom_range(1, 0));
         end
         kind = $urandom_range(99, 0);
         if (kind < 50) begin
            len = $urandom_range(6, 1);
            send_prefix(encode_char(pick_value(len), len), len, $urandom_range(7, 0) == 0);
            sent += len;
         end else if (kind < 62) begin
            // overlong: value small enough for a shorter form
            len = $urandom_range(6, 2);
            enc = encode_char(31'($urandom_range(floor_for(len - 1) - 1, 0)), len);
            send_prefix(enc, len, $urandom_range(7, 0) == 0);
            sent += len;
         end else if (kind < 72) begin
            // buffer ends inside the sequence
            len = $urandom_range(6, 2);
            cut = $urandom_range(len - 1, 1);
            send_prefix(encode_char(pick_value(len), len), cut, 1'b1);
            sent += cut;
         end else if (kind < 82) begin
            // open sequence hit by a byte without the 10xxxxxx tag
            len = $urandom_range(6, 2);
            cut = $urandom_range(len - 1, 1);
            send_prefix(encode_char(pick_value(len), len), cut, 1'b0);
            b = 8'($urandom_range(255, 0));
            if ((b & TRAIL_TAG_MASK) == TRAIL_TAG)
               b = b ^ 8'h40;
            send_byte(b, $urandom_range(3, 0) == 0);
            sent += cut + 1;
         end else begin
            send_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
            sent += 1;
         end
      end
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = '0;
      req_ch.end_of_buffer = 1'b0;
      close_sequence();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_single_bytes();
      test_bad_leads();
      test_longest_sequence();
      test_rejected_values();
      test_bad_trailer();
      test_early_end();
      test_random_streams();

      req_ch.valid <= 1'b0;
      // wait for every predicted result; the drain catches stray extras
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : utf8_sequence_decoder_tb
`default_nettype wire
